// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL modules; included by tmor_scan.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, held off while in reset.
`define TMOR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication, held off while in reset.
`define TMOR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tmor_pkg.sv =====
// Shared types and constants for the TCP MSS option rewriter.
// No dependencies; imported by every module of the block.
package tmor_pkg;

  localparam int MAX_OPTION_BYTES = 40;

  localparam logic [15:0] NEW_MSS_RESET = 16'd1460;

  // TCP option kinds
  localparam logic [7:0] KIND_EOL        = 8'd0;
  localparam logic [7:0] KIND_NOP        = 8'd1;
  localparam logic [7:0] KIND_MSS        = 8'd2;
  localparam logic [7:0] KIND_WINDOW     = 8'd3;
  localparam logic [7:0] KIND_SACK_OK    = 8'd4;
  localparam logic [7:0] KIND_TIMESTAMP  = 8'd8;
  localparam logic [7:0] KIND_QUICKSTART = 8'd27;

  // fixed option lengths
  localparam logic [6:0] LEN_MSS        = 7'd4;
  localparam logic [3:0] LEN_WINDOW     = 4'd3;
  localparam logic [3:0] LEN_SACK_OK    = 4'd2;
  localparam logic [3:0] LEN_TIMESTAMP  = 4'd10;
  localparam logic [3:0] LEN_QUICKSTART = 4'd8;

  // MSS option byte sequence after the kind byte
  localparam logic [1:0] PI_LEN     = 2'd0;
  localparam logic [1:0] PI_MSS_HI  = 2'd1;
  localparam logic [1:0] PI_MSS_LO  = 2'd2;

  localparam logic [1:0] REG_NEW_MSS_ADDR = 2'b00;

  typedef enum logic [3:0] {
    PH_SCAN  = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_PATCH = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_rewritten;
    logic       last_byte;
  } result_t;

  // area length clamp: zero reads as one, above max saturates
  function automatic logic [5:0] sat_len(input logic [5:0] len);
    logic [5:0] r;
    r = len;
    if (len == 6'd0) begin
      r = 6'd1;
    end else if (len > 6'(MAX_OPTION_BYTES)) begin
      r = 6'(MAX_OPTION_BYTES);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/tcp_mss_option_rewriter_top.sv =====
// An accepted byte is held in the input register, scanned, and registered in the result register for the output ports.
// Throughput: one option byte per cycle; an input register and a result
// register carry the scanner, and both advance together unless out_stall holds.
// Reset (rst_n low, synchronous): pipeline empty, scan state cleared, new_mss = 1460.
// Depends on tmor_pkg, tmor_cfg and tmor_scan.
module tcp_mss_option_rewriter_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_option_byte,
  input  logic        in_first_byte,
  input  logic [5:0]  in_area_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_was_rewritten,
  output logic        out_last_byte,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tmor_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_first_r;
  logic [5:0]  s1_len_r;
  logic        out_valid_r;
  result_t     out_r, scan_res;
  logic [15:0] new_mss;
  logic        out_ready, s1_ready, adv;

  tmor_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .new_mss     (new_mss)
  );

  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_ready;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_stall  = !s1_ready;

  tmor_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (adv),
    .option_byte (s1_byte_r),
    .first_byte  (s1_first_r),
    .area_length (s1_len_r),
    .new_mss     (new_mss),
    .res         (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_byte_r  <= in_option_byte;
      s1_first_r <= in_first_byte;
      s1_len_r   <= in_area_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= scan_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_r.out_byte;
  assign out_was_rewritten = out_r.was_rewritten;
  assign out_last_byte     = out_r.last_byte;

endmodule

// ===== hw/rtl/tmor_cfg.sv =====
// APB-style register file holding the MSS value to write.
// Depends on tmor_pkg.
module tmor_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic [15:0] new_mss
);
  import tmor_pkg::*;

  logic [15:0] new_mss_r;
  logic        wr_en;

  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_mss_r <= NEW_MSS_RESET;
    end else if (wr_en) begin
      new_mss_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_NEW_MSS_ADDR) ? {16'd0, new_mss_r} : 32'd0;
  assign new_mss    = new_mss_r;

endmodule

// ===== hw/rtl/tmor_scan.sv =====
// Option scanner: holds the parse state and decides each byte's output.
// Depends on tmor_pkg and assert_macros.svh.
module tmor_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          option_byte,
  input  logic                first_byte,
  input  logic [5:0]          area_length,
  input  logic [15:0]         new_mss,
  output tmor_pkg::result_t   res
);
  import tmor_pkg::*;

  `include "assert_macros.svh"

  phase_t     phase_r, phase_nxt, ph;
  logic [3:0] skip_r, skip_nxt, skip, skip_dec;
  logic [5:0] bpos_r, bpos_nxt, bpos;
  logic [5:0] tlen_r, tlen_nxt, tlen;
  logic [1:0] pidx_r, pidx_nxt, pidx;
  logic       in_area;

  always_comb begin
    ph   = phase_r;
    skip = skip_r;
    bpos = bpos_r;
    tlen = tlen_r;
    pidx = pidx_r;
    if (first_byte) begin
      ph   = PH_SCAN;
      skip = 4'd0;
      bpos = 6'd0;
      tlen = sat_len(area_length);
      pidx = PI_LEN;
    end

    phase_nxt = ph;
    skip_nxt  = skip;
    bpos_nxt  = bpos;
    tlen_nxt  = tlen;
    pidx_nxt  = pidx;
    skip_dec  = (skip != 4'd0) ? skip - 4'd1 : skip;
    res.out_byte      = option_byte;
    res.was_rewritten = 1'b0;
    res.last_byte     = 1'b0;

    in_area = bpos < tlen;
    if (!in_area) begin
      phase_nxt = PH_DONE;
    end else begin
      unique case (ph)
        PH_SCAN: begin
          unique case (option_byte)
            KIND_NOP: ;
            KIND_MSS: begin
              // whole 4-byte option must fit in the area
              if ({1'b0, bpos} + LEN_MSS <= {1'b0, tlen}) begin
                phase_nxt = PH_PATCH;
                pidx_nxt  = PI_LEN;
              end else begin
                phase_nxt = PH_DONE;
              end
            end
            KIND_WINDOW: begin
              skip_nxt  = LEN_WINDOW - 4'd1;
              phase_nxt = PH_SKIP;
            end
            KIND_SACK_OK: begin
              skip_nxt  = LEN_SACK_OK - 4'd1;
              phase_nxt = PH_SKIP;
            end
            KIND_TIMESTAMP: begin
              skip_nxt  = LEN_TIMESTAMP - 4'd1;
              phase_nxt = PH_SKIP;
            end
            KIND_QUICKSTART: begin
              skip_nxt  = LEN_QUICKSTART - 4'd1;
              phase_nxt = PH_SKIP;
            end
            default: phase_nxt = PH_DONE;  // end-of-list or unknown kind
          endcase
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 4'd0) begin
            phase_nxt = PH_SCAN;
          end
        end
        PH_PATCH: begin
          priority if (pidx == PI_LEN) begin
            pidx_nxt = PI_MSS_HI;
          end else if (pidx == PI_MSS_HI) begin
            res.out_byte      = new_mss[15:8];
            res.was_rewritten = 1'b1;
            pidx_nxt          = PI_MSS_LO;
          end else begin
            res.out_byte      = new_mss[7:0];
            res.was_rewritten = 1'b1;
            pidx_nxt          = PI_LEN;
            phase_nxt         = PH_DONE;
          end
        end
        PH_DONE: ;
        default: phase_nxt = PH_DONE;
      endcase
      if (bpos + 6'd1 == tlen) begin
        res.last_byte = 1'b1;
        phase_nxt     = PH_DONE;
      end
      bpos_nxt = bpos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SCAN;
      skip_r  <= 4'd0;
      bpos_r  <= 6'd0;
      tlen_r  <= 6'd0;
      pidx_r  <= PI_LEN;
    end else if (fire) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      bpos_r  <= bpos_nxt;
      tlen_r  <= tlen_nxt;
      pidx_r  <= pidx_nxt;
    end
  end

  `TMOR_ASSERT(a_skip_nonzero, phase_r != PH_SKIP || skip_r != 4'd0, "skip phase with zero count")
  `TMOR_ASSERT_NEXT(a_pos_in_area, fire, bpos_r <= tlen_r, "byte position past area end")
  `TMOR_ASSERT_NEXT(a_mss_low_follows, fire && res.was_rewritten && pidx == PI_MSS_HI && !res.last_byte, phase_r == PH_PATCH && pidx_r == PI_MSS_LO, "MSS low byte not pending after high byte")

endmodule
